// ===== rtl/linear_probe_hash_set_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Linear probe hash set - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_UNIT_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_UNIT_DEFINES_SVH

// same-cycle implication
`define LPHS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lphs: implication check failed");

// next-cycle implication
`define LPHS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lphs: next-cycle check failed");

`endif

// ===== rtl/lphs_pkg.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash set - package
// Field widths, status and action codes, slot markers and shared types.
// ---------------------------------------------------------------------------
package lphs_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned SZ_W    = 11;
	localparam int unsigned PROBE_W = 10;
	localparam int unsigned ACT_W   = 2;
	localparam int unsigned ST_W    = 3;
	localparam int unsigned CFG_W   = 2;

	localparam int unsigned SLOTS_DEF = 1024;

	localparam logic [SZ_W-1:0] TS_RESET  = SZ_W'(1024);
	localparam logic [SZ_W-1:0] CAP_RESET = SZ_W'(787);

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_INVALID   = 3'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd2;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd3;
	localparam logic [ST_W-1:0] ST_PRESENT   = 3'd4;
	localparam logic [ST_W-1:0] ST_ABSENT    = 3'd5;

	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic [CFG_W-1:0] CFG_TABLE_SIZE = 2'd0;
	localparam logic [CFG_W-1:0] CFG_CAPACITY   = 2'd1;

	localparam logic [KEY_W-1:0] MARK_EMPTY   = 32'h0000_0000;
	localparam logic [KEY_W-1:0] MARK_REMOVED = 32'hFFFF_FFFF;

	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

// ===== rtl/lphs_mod.sv =====
// ---------------------------------------------------------------------------
// Linear probe hash set - modulo unit
// Restoring remainder of a 32-bit magnitude by the table size, two bits
// per cycle; done pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
module lphs_mod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lphs_pkg::KEY_W-1:0]     dividend,
	input  logic [lphs_pkg::SZ_W-1:0]      divisor,
	output lphs_pkg::mod_stat_t            stat,
	output logic [lphs_pkg::SZ_W-1:0]      rem
);

	localparam int unsigned STEPS = lphs_pkg::KEY_W / 2;
	localparam int unsigned CNT_W = $clog2(STEPS);
	localparam int unsigned R_W   = lphs_pkg::SZ_W;

	logic [lphs_pkg::KEY_W-1:0] q_q;
	logic [R_W-1:0]             d_q;
	logic [R_W-1:0]             r_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [R_W:0]   t1, t2, r1, r2;

	always_comb begin
		t1 = {r_q, q_q[lphs_pkg::KEY_W-1]};
		r1 = (t1 >= {1'b0, d_q}) ? (t1 - {1'b0, d_q}) : t1;
		t2 = {r1[R_W-1:0], q_q[lphs_pkg::KEY_W-2]};
		r2 = (t2 >= {1'b0, d_q}) ? (t2 - {1'b0, d_q}) : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNT_W'(STEPS - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[lphs_pkg::KEY_W-3:0], 2'b00};
			r_q <= r2[R_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = r_q;

endmodule

// ===== rtl/linear_probe_hash_set_unit.sv =====
// Sequence: accept, the home-slot modulo in S_DIV, then S_READ and S_CHECK per
// probed slot (one slot store read each), then S_FIN loads the output beat.
// Rejected items (invalid key, full, empty, unused action) skip the modulo to S_FIN.
// Throughput: one item at a time.
// Reset: counters clear at once; the slot store is then cleared one entry per cycle
// through all SLOTS entries, with the input stalled. Configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// Linear probe hash set - top level
// Open-addressing set of signed keys in a slot store with one write and one read port, with a
// probe sequencer and a shared modulo unit for the home slot.
// ---------------------------------------------------------------------------
`include "linear_probe_hash_set_unit_defines.svh"

module linear_probe_hash_set_unit #(
	parameter int unsigned SLOTS = lphs_pkg::SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lphs_pkg::ACT_W-1:0]      action,
	input  logic signed [lphs_pkg::KEY_W-1:0] key,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lphs_pkg::ST_W-1:0]       status,
	output logic                            found,
	output logic [lphs_pkg::SZ_W-1:0]       item_count,
	output logic [lphs_pkg::PROBE_W-1:0]    max_probe,
	output logic [lphs_pkg::KEY_W-1:0]      total_collisions,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lphs_pkg::CFG_W-1:0]      cfg_index,
	input  logic [lphs_pkg::SZ_W-1:0]       cfg_data
);

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned SZ_W  = lphs_pkg::SZ_W;
	localparam int unsigned KEY_W = lphs_pkg::KEY_W;
	localparam int unsigned NX_W  = (IDX_W + 1 > SZ_W) ? IDX_W + 1 : SZ_W;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam logic [1:0] M_WALK   = 2'd0;
	localparam logic [1:0] M_DUP    = 2'd1;
	localparam logic [1:0] M_SEARCH = 2'd2;

	logic [KEY_W-1:0] mem [SLOTS];

	logic [2:0]                     state_q;
	logic [1:0]                     mode_q;
	logic                           clr_busy_q;
	logic [IDX_W-1:0]               clr_addr_q;

	logic [lphs_pkg::ACT_W-1:0]     act_q;
	logic [KEY_W-1:0]               key_q;
	logic [SZ_W-1:0]                size_q;
	logic [IDX_W-1:0]               home_q;
	logic [IDX_W-1:0]               idx_q;
	logic [SZ_W-1:0]                n_q;
	logic [KEY_W-1:0]               rdata_s1;

	logic [SZ_W-1:0]                ts_q;
	logic [SZ_W-1:0]                cap_q;
	logic [SZ_W-1:0]                count_q;
	logic [lphs_pkg::PROBE_W-1:0]   lp_q;
	logic [KEY_W-1:0]               coll_q;

	logic [lphs_pkg::ST_W-1:0]      res_status_q;
	logic                           res_found_q;

	logic                           out_valid_q;
	logic [lphs_pkg::ST_W-1:0]      out_status_q;
	logic                           out_found_q;
	logic [SZ_W-1:0]                out_count_q;
	logic [lphs_pkg::PROBE_W-1:0]   out_lp_q;
	logic [KEY_W-1:0]               out_coll_q;

	logic                           accept;
	logic [KEY_W-1:0]               key_u;
	logic [KEY_W-1:0]               mag;
	logic                           key_bad;
	logic [SZ_W-1:0]                size_raw;
	logic [SZ_W-1:0]                size_eff;

	logic                           mod_start;
	lphs_pkg::mod_stat_t            mod_stat;
	logic [SZ_W-1:0]                mod_rem;

	logic [NX_W-1:0]                idx_inc;
	logic [IDX_W-1:0]               idx_next;
	logic                           walk_end;
	logic                           scan_end;
	logic                           hit;
	logic                           slot_empty;
	logic                           home_removed;
	logic [KEY_W:0]                 coll_sum;
	logic [KEY_W-1:0]               coll_sat;

	logic                           mem_we;
	logic [IDX_W-1:0]               mem_wa;
	logic [KEY_W-1:0]               mem_wd;

	assign in_stall  = clr_busy_q || (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign key_u    = key;
	assign mag      = key_u[KEY_W-1] ? (KEY_W'(0) - key_u) : key_u;
	assign key_bad  = (key_u == lphs_pkg::MARK_EMPTY) || (key_u == lphs_pkg::MARK_REMOVED);
	assign size_raw = (ts_q == '0) ? SZ_W'(1) : ts_q;
	assign size_eff = (32'(size_raw) > 32'(SLOTS)) ? SZ_W'(SLOTS) : size_raw;

	assign mod_start = accept && !key_bad && (
		((action == lphs_pkg::ACT_INSERT) && (count_q < cap_q)) ||
		((action == lphs_pkg::ACT_REMOVE) && (count_q != '0)) ||
		((action == lphs_pkg::ACT_LOOKUP) && (count_q != '0)));

	lphs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mag),
		.divisor  (size_eff),
		.stat     (mod_stat),
		.rem      (mod_rem)
	);

	assign idx_inc      = NX_W'(idx_q) + NX_W'(1);
	assign idx_next     = (idx_inc >= NX_W'(size_q)) ? '0 : idx_inc[IDX_W-1:0];
	assign walk_end     = (n_q >= size_q);
	assign scan_end     = (n_q > {1'b0, lp_q});
	assign hit          = (rdata_s1 == key_q);
	assign slot_empty   = (rdata_s1 == lphs_pkg::MARK_EMPTY);
	assign home_removed = (n_q == '0) && (rdata_s1 == lphs_pkg::MARK_REMOVED);
	assign coll_sum     = {1'b0, coll_q} + (KEY_W + 1)'(n_q);
	assign coll_sat     = coll_sum[KEY_W] ? '1 : coll_sum[KEY_W-1:0];

	// slot store write port
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_q;
		mem_wd = key_q;
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = lphs_pkg::MARK_EMPTY;
		end else if (state_q == S_READ && mode_q == M_DUP && scan_end) begin
			mem_we = 1'b1;
			mem_wa = home_q;
		end else if (state_q == S_CHECK) begin
			case (mode_q)
				M_WALK: begin
					mem_we = !home_removed && slot_empty;
				end
				M_SEARCH: begin
					mem_we = hit && (act_q == lphs_pkg::ACT_REMOVE);
					mem_wd = lphs_pkg::MARK_REMOVED;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rdata_s1 <= mem[idx_q];
		end
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == IDX_W'(SLOTS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= lphs_pkg::TS_RESET;
			cap_q <= lphs_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lphs_pkg::CFG_TABLE_SIZE: ts_q  <= cfg_data;
				lphs_pkg::CFG_CAPACITY:   cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// probe sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			lp_q         <= '0;
			coll_q       <= '0;
			res_status_q <= lphs_pkg::ST_OK;
			res_found_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_found_q <= 1'b0;
						if (mod_start) begin
							state_q <= S_DIV;
						end else begin
							state_q <= S_FIN;
							if (key_bad && action != lphs_pkg::ACT_UNUSED) begin
								res_status_q <= lphs_pkg::ST_INVALID;
							end else begin
								case (action)
									lphs_pkg::ACT_INSERT: res_status_q <= lphs_pkg::ST_OVERFLOW;
									lphs_pkg::ACT_REMOVE: res_status_q <= lphs_pkg::ST_UNDERFLOW;
									lphs_pkg::ACT_LOOKUP: res_status_q <= lphs_pkg::ST_ABSENT;
									default:              res_status_q <= lphs_pkg::ST_OK;
								endcase
							end
						end
					end
				end
				S_DIV: begin
					if (mod_stat.done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (mode_q == M_WALK) begin
						if (walk_end) begin
							coll_q       <= coll_sat;
							res_status_q <= lphs_pkg::ST_OVERFLOW;
							state_q      <= S_FIN;
						end else begin
							state_q <= S_CHECK;
						end
					end else if (scan_end) begin
						state_q <= S_FIN;
						if (mode_q == M_DUP) begin
							count_q      <= count_q + 1'b1;
							res_status_q <= lphs_pkg::ST_OK;
						end else begin
							res_status_q <= lphs_pkg::ST_ABSENT;
						end
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					case (mode_q)
						M_WALK: begin
							if (home_removed) begin
								state_q <= S_READ;
							end else if (slot_empty) begin
								coll_q       <= coll_sat;
								count_q      <= count_q + 1'b1;
								res_status_q <= lphs_pkg::ST_OK;
								state_q      <= S_FIN;
								if (n_q > {1'b0, lp_q}) begin
									lp_q <= n_q[lphs_pkg::PROBE_W-1:0];
								end
							end else if (hit) begin
								coll_q       <= coll_sat;
								res_status_q <= lphs_pkg::ST_PRESENT;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_READ;
							end
						end
						M_DUP: begin
							if (hit) begin
								res_status_q <= lphs_pkg::ST_PRESENT;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_READ;
							end
						end
						default: begin
							if (hit) begin
								res_status_q <= lphs_pkg::ST_OK;
								state_q      <= S_FIN;
								if (act_q == lphs_pkg::ACT_REMOVE) begin
									count_q <= count_q - 1'b1;
								end else begin
									res_found_q <= 1'b1;
								end
							end else if (slot_empty) begin
								res_status_q <= lphs_pkg::ST_ABSENT;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_READ;
							end
						end
					endcase
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item context and probe position
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			key_q  <= key_u;
			size_q <= size_eff;
			mode_q <= (action == lphs_pkg::ACT_INSERT) ? M_WALK : M_SEARCH;
		end
		if (state_q == S_DIV && mod_stat.done) begin
			home_q <= IDX_W'(mod_rem);
			idx_q  <= IDX_W'(mod_rem);
			n_q    <= '0;
		end
		if (state_q == S_CHECK) begin
			if (mode_q == M_WALK && home_removed) begin
				mode_q <= M_DUP;
			end else begin
				n_q   <= n_q + 1'b1;
				idx_q <= idx_next;
			end
		end
	end

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_count_q  <= count_q;
			out_lp_q     <= lp_q;
			out_coll_q   <= coll_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign found            = out_found_q;
	assign item_count       = out_count_q;
	assign max_probe        = out_lp_q;
	assign total_collisions = out_coll_q;

	`LPHS_ASSERT_IMP(a_mod_in_div, mod_stat.busy || mod_stat.done, state_q == S_DIV)
	`LPHS_ASSERT_IMP(a_idx_in_table, state_q == S_CHECK, NX_W'(idx_q) < NX_W'(size_q))
	`LPHS_ASSERT_IMP(a_walk_bound, state_q == S_CHECK && mode_q == M_WALK, n_q < size_q)
	`LPHS_ASSERT_NXT(a_fin_holds, state_q == S_FIN && out_valid_q && out_stall, state_q == S_FIN)
	`LPHS_ASSERT_IMP(a_no_item_in_clear, clr_busy_q, state_q == S_IDLE)

endmodule
